FILE: src/mfr_pkg.sv
package mfr_pkg;

	// Target and source format codes
	localparam logic [1:0] FMT_BIN   = 2'd0;
	localparam logic [1:0] FMT_HEX   = 2'd1;
	localparam logic [1:0] FMT_HEXTS = 2'd2;
	localparam logic [1:0] FMT_NONE  = 2'd3;

	// Framing characters
	localparam logic [7:0] ESC_BYTE     = 8'h1A;
	localparam logic [7:0] CHR_TYPE4    = 8'h34;
	localparam logic [7:0] CHR_TYPE5    = 8'h35;
	localparam logic [7:0] CHR_STAR     = 8'h2A;
	localparam logic [7:0] CHR_AT       = 8'h40;
	localparam logic [7:0] CHR_SEMI     = 8'h3B;
	localparam logic [7:0] CHR_NL       = 8'h0A;
	localparam logic [7:0] CHR_ZERO     = 8'h30;
	localparam logic [7:0] CHR_HEX_BASE = 8'h37;

	// Last byte and nibble index inside the timestamp
	localparam logic [3:0] TS_LAST_BYTE = 4'd5;
	localparam logic [3:0] TS_LAST_NIB  = 4'd11;

	// Item as taken from the input queue port
	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        byte_present;
		logic        first_of_message;
		logic        last_of_message;
		logic [7:0]  message_type;
		logic [47:0] timestamp;
		logic [7:0]  signal_level;
		logic [1:0]  source_format;
	} item_t;

	// Classified job handed from front to back
	typedef struct packed {
		logic        first;
		logic        present;
		logic        last;
		logic [1:0]  fmt;
		logic [7:0]  mtype;
		logic [47:0] ts;
		logic [7:0]  sig;
		logic [7:0]  pb;
	} job_t;

	// One encoded output byte
	typedef struct packed {
		logic [7:0] out_byte;
		logic       end_of_message;
		logic       last_of_run;
	} res_t;

	// Back-end sequencer phases
	typedef enum logic [2:0] {
		PH_START,
		PH_LEAD,
		PH_TYPE,
		PH_TS,
		PH_SIG,
		PH_PAY,
		PH_SEMI,
		PH_NL
	} phase_t;

	// Uppercase hex character for one nibble
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) begin
			return CHR_ZERO + {4'h0, nib};
		end
		return CHR_HEX_BASE + {4'h0, nib};
	endfunction

endpackage

FILE: src/mfr_fifo.sv
module mfr_fifo
	#(
		parameter int WIDTH = 8,
		parameter int DEPTH = 2
	)
	(
		input  logic             clk,
		input  logic             arst_n,
		input  logic             push,
		input  logic [WIDTH-1:0] wdata,
		output logic             full,
		input  logic             pop,
		output logic [WIDTH-1:0] rdata,
		output logic             empty
	);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/mfr_front.sv
module mfr_front
	import mfr_pkg::*;
	(
		input  logic       clk,
		input  logic       arst_n,
		input  logic       cfg_valid,
		input  logic [1:0] cfg_data,
		input  logic       accept,
		input  item_t      item,
		output logic       job_push,
		output job_t       job
	);

	logic [1:0] target_format_q;
	logic [1:0] latched_fmt_q;
	logic       suppress_q;
	logic [1:0] fmt;
	logic       supp;
	logic       cfg_msg;

	assign cfg_msg = (item.message_type == CHR_TYPE4) || (item.message_type == CHR_TYPE5);

	// Pick format and suppression for this item
	always_comb begin
		if (item.first_of_message) begin
			fmt  = target_format_q;
			supp = (target_format_q == FMT_NONE) || ((target_format_q != FMT_BIN) && cfg_msg);
		end else begin
			fmt  = latched_fmt_q;
			supp = suppress_q;
		end
	end

	// Build the job; drop items that produce nothing
	always_comb begin
		job.first   = item.first_of_message;
		job.present = item.byte_present;
		job.last    = item.last_of_message;
		job.fmt     = fmt;
		job.mtype   = item.message_type;
		job.ts      = (item.source_format == FMT_HEX) ? '0 : item.timestamp;
		job.sig     = (item.source_format == FMT_BIN) ? item.signal_level : '0;
		job.pb      = item.payload_byte;
		job_push    = accept && !supp && (item.first_of_message || item.byte_present ||
			(item.last_of_message && (fmt != FMT_BIN)));
	end

	// Hold the format register and per-message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_format_q <= FMT_BIN;
			latched_fmt_q   <= FMT_BIN;
			suppress_q      <= 1'b0;
		end else begin
			if (cfg_valid) begin
				target_format_q <= cfg_data;
			end
			if (accept && item.first_of_message) begin
				latched_fmt_q <= fmt;
				suppress_q    <= supp;
			end
		end
	end

endmodule

FILE: src/mfr_back.sv
module mfr_back
	import mfr_pkg::*;
	(
		input  logic clk,
		input  logic arst_n,
		input  logic job_empty,
		input  job_t job,
		output logic job_pop,
		input  logic res_full,
		output logic res_push,
		output res_t res
	);

	phase_t     phase_q;
	logic [3:0] cnt_q;
	logic       dup_q;

	phase_t     eff;
	phase_t     nxt_phase;
	logic [3:0] nxt_cnt;
	logic       nxt_dup;
	logic       done;
	logic       go;
	logic       is_bin;
	logic       trailer;
	logic [47:0] ts_byte_sh;
	logic [47:0] ts_nib_sh;
	logic [7:0]  esc_src;
	logic        need_dup;

	assign is_bin     = (job.fmt == FMT_BIN);
	assign trailer    = job.last && !is_bin;
	assign go         = !job_empty && !res_full;
	assign ts_byte_sh = job.ts << {cnt_q, 3'b000};
	assign ts_nib_sh  = job.ts << {cnt_q, 2'b00};

	// Start a fresh job at its first phase
	always_comb begin
		if (phase_q != PH_START) begin
			eff = phase_q;
		end else if (job.first) begin
			eff = PH_LEAD;
		end else if (job.present) begin
			eff = PH_PAY;
		end else begin
			eff = PH_SEMI;
		end
	end

	// Select the byte subject to escape doubling
	always_comb begin
		case (eff)
			PH_TS:   esc_src = ts_byte_sh[47:40];
			PH_SIG:  esc_src = job.sig;
			default: esc_src = job.pb;
		endcase
		need_dup = is_bin && (esc_src == ESC_BYTE) && !dup_q;
	end

	// Next phase
	always_comb begin
		nxt_phase = PH_START;
		nxt_cnt   = '0;
		nxt_dup   = 1'b0;
		done      = 1'b0;
		case (eff)
			PH_LEAD: begin
				if (is_bin) begin
					nxt_phase = PH_TYPE;
				end else if (job.fmt == FMT_HEXTS) begin
					nxt_phase = PH_TS;
				end else if (job.present) begin
					nxt_phase = PH_PAY;
				end else if (trailer) begin
					nxt_phase = PH_SEMI;
				end else begin
					done = 1'b1;
				end
			end
			PH_TYPE: nxt_phase = PH_TS;
			PH_TS: begin
				if (need_dup) begin
					nxt_phase = PH_TS;
					nxt_cnt   = cnt_q;
					nxt_dup   = 1'b1;
				end else if (cnt_q == (is_bin ? TS_LAST_BYTE : TS_LAST_NIB)) begin
					if (is_bin) begin
						nxt_phase = PH_SIG;
					end else if (job.present) begin
						nxt_phase = PH_PAY;
					end else if (trailer) begin
						nxt_phase = PH_SEMI;
					end else begin
						done = 1'b1;
					end
				end else begin
					nxt_phase = PH_TS;
					nxt_cnt   = cnt_q + 4'd1;
				end
			end
			PH_SIG: begin
				if (need_dup) begin
					nxt_phase = PH_SIG;
					nxt_dup   = 1'b1;
				end else if (job.present) begin
					nxt_phase = PH_PAY;
				end else begin
					done = 1'b1;
				end
			end
			PH_PAY: begin
				if (need_dup) begin
					nxt_phase = PH_PAY;
					nxt_dup   = 1'b1;
				end else if (!is_bin && (cnt_q == '0)) begin
					nxt_phase = PH_PAY;
					nxt_cnt   = 4'd1;
				end else if (trailer) begin
					nxt_phase = PH_SEMI;
				end else begin
					done = 1'b1;
				end
			end
			PH_SEMI: nxt_phase = PH_NL;
			PH_NL:   done = 1'b1;
			default: done = 1'b1;
		endcase
	end

	// Output byte for the current phase
	always_comb begin
		case (eff)
			PH_LEAD: begin
				if (is_bin) begin
					res.out_byte = ESC_BYTE;
				end else if (job.fmt == FMT_HEXTS) begin
					res.out_byte = CHR_AT;
				end else begin
					res.out_byte = CHR_STAR;
				end
			end
			PH_TYPE: res.out_byte = job.mtype;
			PH_TS:   res.out_byte = is_bin ? esc_src : hex_char(ts_nib_sh[47:44]);
			PH_SIG:  res.out_byte = esc_src;
			PH_PAY: begin
				if (is_bin) begin
					res.out_byte = esc_src;
				end else begin
					res.out_byte = hex_char((cnt_q == '0) ? job.pb[7:4] : job.pb[3:0]);
				end
			end
			PH_SEMI: res.out_byte = CHR_SEMI;
			PH_NL:   res.out_byte = CHR_NL;
			default: res.out_byte = CHR_NL;
		endcase
		res.last_of_run    = done;
		res.end_of_message = done && job.last;
		res_push           = go;
		job_pop            = go && done;
	end

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			cnt_q   <= '0;
			dup_q   <= 1'b0;
		end else if (go) begin
			phase_q <= done ? PH_START : nxt_phase;
			cnt_q   <= done ? '0 : nxt_cnt;
			dup_q   <= done ? 1'b0 : nxt_dup;
		end
	end

	a_job_held: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_START) |-> !job_empty)
		else $error("sequencer in progress without a job");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_TS) |-> (cnt_q <= TS_LAST_NIB))
		else $error("timestamp index out of range");

	a_dup_bin: assert property (@(posedge clk) disable iff (!arst_n)
		dup_q |-> (is_bin && ((phase_q == PH_TS) || (phase_q == PH_SIG) || (phase_q == PH_PAY))))
		else $error("escape repeat outside binary escaped field");

	a_pop_last: assert property (@(posedge clk) disable iff (!arst_n)
		(go && done) |=> (phase_q == PH_START))
		else $error("sequencer did not return to start after a job");

endmodule

FILE: src/mode_s_frame_reencoder.sv
// Mode S frame re-encoder.
// Input queue port: one item per payload byte, header fields on the first
// item of a message; an item is taken when push is high and full is low.
// Result queue port: encoded bytes appear while empty is low and are taken
// with pop. last_of_run marks the final byte of one item, end_of_message the
// final byte of a message. Dropped messages (hex or unused format) give nothing.
// Configuration: cfg_valid/cfg_ready write the 2-bit target format (always
// ready); it is sampled on the first item of each message.
// Path: an accepted item that gives bytes is queued as a job; the sequencer
// writes its bytes to the result queue, whose head is on the result ports.
// Throughput: one output byte per cycle from a single back-end sequencer while
// the result queue has room; an item gives 1 or 2 bytes for a payload byte
// (plus 2 for the hex trailer), up to 18 for a message start. A job queue
// of QUEUE_DEPTH entries lets input keep flowing while the sequencer works.
// Reset clears both queues and selects binary format. When the receiver holds
// off, the result queue fills, the sequencer stops, then the job queue fills
// and full rises; nothing is lost.
module mode_s_frame_reencoder
	import mfr_pkg::*;
	#(
		parameter int QUEUE_DEPTH = 2,
		parameter int OUT_DEPTH   = 2
	)
	(
		input  logic        clk,
		input  logic        arst_n,
		input  logic        cfg_valid,
		output logic        cfg_ready,
		input  logic [1:0]  cfg_data,
		input  logic        push,
		output logic        full,
		input  logic [7:0]  payload_byte,
		input  logic        byte_present,
		input  logic        first_of_message,
		input  logic        last_of_message,
		input  logic [7:0]  message_type,
		input  logic [47:0] timestamp,
		input  logic [7:0]  signal_level,
		input  logic [1:0]  source_format,
		output logic        empty,
		input  logic        pop,
		output logic [7:0]  out_byte,
		output logic        end_of_message,
		output logic        last_of_run
	);

	item_t item;
	job_t  job_in;
	job_t  job_out;
	res_t  res_in;
	res_t  res_out;
	logic  job_push;
	logic  job_pop;
	logic  job_empty;
	logic  res_push;
	logic  res_full;

	assign cfg_ready = 1'b1;

	// Gather item fields
	always_comb begin
		item.payload_byte     = payload_byte;
		item.byte_present     = byte_present;
		item.first_of_message = first_of_message;
		item.last_of_message  = last_of_message;
		item.message_type     = message_type;
		item.timestamp        = timestamp;
		item.signal_level     = signal_level;
		item.source_format    = source_format;
	end

	mfr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.accept   (push && !full),
		.item     (item),
		.job_push (job_push),
		.job      (job_in)
	);

	mfr_fifo #(.WIDTH($bits(job_t)), .DEPTH(QUEUE_DEPTH)) u_job_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (job_push),
		.wdata (job_in),
		.full  (full),
		.pop   (job_pop),
		.rdata (job_out),
		.empty (job_empty)
	);

	mfr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_empty(job_empty),
		.job      (job_out),
		.job_pop  (job_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_in)
	);

	mfr_fifo #(.WIDTH($bits(res_t)), .DEPTH(OUT_DEPTH)) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_in),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_out),
		.empty (empty)
	);

	assign out_byte       = res_out.out_byte;
	assign end_of_message = res_out.end_of_message;
	assign last_of_run    = res_out.last_of_run;

endmodule

FILE: tb/tb_top.sv
module tb_top
	import mfr_pkg::*;
	();

	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 40;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_data;
	logic        push;
	logic        full;
	item_t       in_item;
	logic        empty;
	logic        pop;
	logic [7:0]  out_byte;
	logic        end_of_message;
	logic        last_of_run;

	// Encoder state as tracked on the testbench side
	logic [1:0]  fmt_reg;
	logic [1:0]  msg_fmt;
	logic        msg_dropped;
	logic [7:0]  run_bytes[$];
	res_t        expected_bytes[$];

	int          send_idle_pct;
	int          recv_idle_pct;
	int          error_count;
	int          results_seen;

	mode_s_frame_reencoder dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.push             (push),
		.full             (full),
		.payload_byte     (in_item.payload_byte),
		.byte_present     (in_item.byte_present),
		.first_of_message (in_item.first_of_message),
		.last_of_message  (in_item.last_of_message),
		.message_type     (in_item.message_type),
		.timestamp        (in_item.timestamp),
		.signal_level     (in_item.signal_level),
		.source_format    (in_item.source_format),
		.empty            (empty),
		.pop              (pop),
		.out_byte         (out_byte),
		.end_of_message   (end_of_message),
		.last_of_run      (last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("FAILURE");
		$finish;
	end

	function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
		string digits;
		digits = "0123456789ABCDEF";
		return digits[nib];
	endfunction

	function automatic void push_hex(input logic [7:0] b);
		run_bytes.push_back(hex_ascii(b[7:4]));
		run_bytes.push_back(hex_ascii(b[3:0]));
	endfunction

	// Double the escape byte in binary output
	function automatic void push_escaped(input logic [7:0] b);
		if (b == ESC_BYTE) begin
			run_bytes.push_back(ESC_BYTE);
		end
		run_bytes.push_back(b);
	endfunction

	// Work out the encoded bytes one accepted item causes and queue them
	function automatic void encode_item(input item_t it);
		logic [47:0] ts;
		logic [7:0]  sig;
		res_t        r;
		ts = it.timestamp;
		sig = it.signal_level;
		run_bytes.delete();
		if (it.first_of_message) begin
			msg_fmt = fmt_reg;
			msg_dropped = (msg_fmt == FMT_NONE) ||
				(msg_fmt != FMT_BIN &&
				 (it.message_type == CHR_TYPE4 || it.message_type == CHR_TYPE5));
			if (it.source_format == FMT_HEX) ts = '0;
			if (it.source_format != FMT_BIN) sig = '0;
			if (!msg_dropped) begin
				case (msg_fmt)
					FMT_BIN: begin
						run_bytes.push_back(ESC_BYTE);
						run_bytes.push_back(it.message_type);
						for (int i = 5; i >= 0; i--) push_escaped(ts[8*i +: 8]);
						push_escaped(sig);
					end
					FMT_HEX: begin
						run_bytes.push_back(CHR_STAR);
					end
					default: begin
						run_bytes.push_back(CHR_AT);
						for (int i = 5; i >= 0; i--) push_hex(ts[8*i +: 8]);
					end
				endcase
			end
		end
		if (!msg_dropped) begin
			if (it.byte_present) begin
				if (msg_fmt == FMT_BIN) push_escaped(it.payload_byte);
				else push_hex(it.payload_byte);
			end
			if (it.last_of_message && msg_fmt != FMT_BIN) begin
				run_bytes.push_back(CHR_SEMI);
				run_bytes.push_back(CHR_NL);
			end
			foreach (run_bytes[k]) begin
				r.out_byte = run_bytes[k];
				r.last_of_run = (k == run_bytes.size() - 1);
				r.end_of_message = it.last_of_message && r.last_of_run;
				expected_bytes.push_back(r);
			end
		end
	endfunction

	function automatic item_t make_item(input logic [7:0] pb, input logic present,
			input logic first, input logic last, input logic [7:0] mtype,
			input logic [47:0] ts, input logic [7:0] sig, input logic [1:0] src);
		item_t it;
		it.payload_byte = pb;
		it.byte_present = present;
		it.first_of_message = first;
		it.last_of_message = last;
		it.message_type = mtype;
		it.timestamp = ts;
		it.signal_level = sig;
		it.source_format = src;
		return it;
	endfunction

	task automatic report_error(input string msg);
		error_count++;
		$display("ERROR: %s", msg);
	endtask

	// Offer one item; push stays high if the next item follows at once
	task automatic push_item(input item_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		push <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (full);
		encode_item(it);
	endtask

	// Hold input until every expected byte is out and the block has settled
	task automatic drain_output();
		push <= 1'b0;
		while (expected_bytes.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_target_format(input logic [1:0] f);
		drain_output();
		cfg_valid <= 1'b1;
		cfg_data <= f;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		fmt_reg = f;
	endtask

	// Receiver: pop at random and check each transaction against the oldest expectation
	initial begin
		res_t want;
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (pop && !empty) begin
					results_seen++;
					if (expected_bytes.size() == 0) begin
						report_error($sformatf("result %0d: byte %h with nothing expected",
							results_seen, out_byte));
					end else begin
						want = expected_bytes.pop_front();
						if (out_byte !== want.out_byte)
							report_error($sformatf("result %0d: out_byte %h, want %h",
								results_seen, out_byte, want.out_byte));
						if (end_of_message !== want.end_of_message)
							report_error($sformatf("result %0d: end_of_message %b, want %b",
								results_seen, end_of_message, want.end_of_message));
						if (last_of_run !== want.last_of_run)
							report_error($sformatf("result %0d: last_of_run %b, want %b",
								results_seen, last_of_run, want.last_of_run));
					end
				end
				pop <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Continuation items before any message start encode as binary
	task automatic test_headless_start();
		push_item(make_item(ESC_BYTE, 1'b1, 1'b0, 1'b0, 8'h00, '0, 8'h00, FMT_BIN));
		push_item(make_item(8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, '0, 8'h00, FMT_BIN));
		// Empty last item in binary gives nothing
		push_item(make_item(8'h00, 1'b0, 1'b0, 1'b1, 8'h00, '0, 8'h00, FMT_BIN));
	endtask

	task automatic test_binary_escaping();
		set_target_format(FMT_BIN);
		push_item(make_item(8'h00, 1'b1, 1'b1, 1'b0, ESC_BYTE, 48'h1A00_FF1A_1A01,
			ESC_BYTE, FMT_BIN));
		push_item(make_item(8'hFF, 1'b1, 1'b0, 1'b0, 8'h00, '0, 8'h00, FMT_BIN));
		push_item(make_item(ESC_BYTE, 1'b1, 1'b0, 1'b1, 8'h00, '0, 8'h00, FMT_BIN));
		// Configuration type passes through in binary
		push_item(make_item(8'h5D, 1'b1, 1'b1, 1'b1, CHR_TYPE4, 48'hFFFF_FFFF_FFFF,
			8'hFF, FMT_BIN));
	endtask

	// Zero the timestamp and signal by source format, including the unused code
	task automatic test_source_formats();
		push_item(make_item(8'h11, 1'b1, 1'b1, 1'b1, 8'h33, 48'h1A1A_1A1A_1A1A,
			ESC_BYTE, FMT_HEX));
		push_item(make_item(8'h22, 1'b1, 1'b1, 1'b1, 8'h32, 48'h0123_4567_89AB,
			8'h80, FMT_HEXTS));
		push_item(make_item(8'h33, 1'b0, 1'b1, 1'b1, 8'h31, 48'h1A23_4567_89AB,
			ESC_BYTE, FMT_NONE));
	endtask

	task automatic test_hex_standard();
		set_target_format(FMT_HEX);
		push_item(make_item(8'h00, 1'b1, 1'b1, 1'b0, 8'h33, 48'h1, 8'h1, FMT_BIN));
		push_item(make_item(8'hFF, 1'b1, 1'b0, 1'b0, 8'h00, '0, 8'h00, FMT_BIN));
		push_item(make_item(8'hA5, 1'b1, 1'b0, 1'b1, 8'h00, '0, 8'h00, FMT_BIN));
		push_item(make_item(8'h12, 1'b1, 1'b1, 1'b0, CHR_TYPE4, 48'h5, 8'h5, FMT_HEX));
		push_item(make_item(8'h34, 1'b1, 1'b0, 1'b1, 8'h00, '0, 8'h00, FMT_HEX));
		// Empty message still gets lead and trailer
		push_item(make_item(8'h00, 1'b0, 1'b1, 1'b1, 8'h32, '0, 8'h00, FMT_HEX));
	endtask

	task automatic test_hex_timestamped();
		set_target_format(FMT_HEXTS);
		push_item(make_item(8'h9C, 1'b1, 1'b1, 1'b1, 8'h33, 48'hFFFF_FFFF_FFFF,
			8'hFF, FMT_HEXTS));
		push_item(make_item(8'h01, 1'b1, 1'b1, 1'b1, CHR_TYPE5, 48'h1234, 8'h0, FMT_BIN));
		push_item(make_item(8'hE7, 1'b1, 1'b1, 1'b1, 8'h32, 48'hABCD_EF01_2345,
			8'h40, FMT_HEX));
	endtask

	task automatic test_unused_format();
		set_target_format(FMT_NONE);
		push_item(make_item(8'h42, 1'b1, 1'b1, 1'b0, 8'h33, 48'h77, 8'h7, FMT_BIN));
		push_item(make_item(8'h43, 1'b1, 1'b0, 1'b1, 8'h00, '0, 8'h00, FMT_BIN));
	endtask

	// A write in the middle of a message applies from the next message on
	task automatic test_format_latch();
		set_target_format(FMT_HEXTS);
		push_item(make_item(8'hC3, 1'b1, 1'b1, 1'b0, 8'h31, 48'h00FF_00FF_00FF,
			8'h10, FMT_BIN));
		set_target_format(FMT_BIN);
		push_item(make_item(8'h3C, 1'b1, 1'b0, 1'b0, 8'h00, '0, 8'h00, FMT_BIN));
		push_item(make_item(ESC_BYTE, 1'b1, 1'b0, 1'b1, 8'h00, '0, 8'h00, FMT_BIN));
		push_item(make_item(8'h77, 1'b1, 1'b1, 1'b1, 8'h31, 48'h1A, 8'h1A, FMT_BIN));
	endtask

	// Mostly well-formed messages with random content, some stray items
	task automatic test_random_traffic(input int n_items, input int send_pct,
			input int recv_pct);
		int          sent;
		int          len;
		int          pos;
		logic [7:0]  mtype;
		logic [47:0] ts;
		logic [7:0]  sig;
		logic [1:0]  src;
		logic [7:0]  pb;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(3) == 0) set_target_format(2'($urandom_range(3)));
			ts = {16'($urandom()), $urandom()};
			if ($urandom_range(2) == 0) begin
				pos = $urandom_range(5);
				ts[8*pos +: 8] = ESC_BYTE;
			end
			sig = ($urandom_range(4) == 0) ? ESC_BYTE : 8'($urandom());
			src = 2'($urandom_range(3));
			if ($urandom_range(99) < 15) begin
				push_item(make_item(8'($urandom()), 1'($urandom()), 1'($urandom()),
					1'($urandom()), 8'($urandom()), ts, sig, src));
				sent++;
			end else begin
				case ($urandom_range(5))
					0:       mtype = CHR_TYPE4;
					1:       mtype = CHR_TYPE5;
					2:       mtype = ESC_BYTE;
					default: mtype = 8'($urandom());
				endcase
				len = $urandom_range(1, 8);
				for (int j = 0; j < len; j++) begin
					pb = ($urandom_range(7) == 0) ? ESC_BYTE : 8'($urandom());
					push_item(make_item(pb, $urandom_range(9) != 0, j == 0, j == len - 1,
						mtype, ts, sig, src));
					sent++;
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = FMT_BIN;
		in_item = '0;
		fmt_reg = FMT_BIN;
		msg_fmt = FMT_BIN;
		msg_dropped = 1'b0;
		error_count = 0;
		results_seen = 0;
		send_idle_pct = 14;
		recv_idle_pct = 87;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_headless_start();
		test_binary_escaping();
		test_source_formats();
		test_hex_standard();
		test_hex_timestamped();
		test_unused_format();
		test_format_latch();
		test_random_traffic(40, 14, 87);
		test_random_traffic(40, 87, 14);
		test_random_traffic(40, 0, 0);
		drain_output();
		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

FILE: sim.f
src/mfr_pkg.sv
src/mfr_fifo.sv
src/mfr_front.sv
src/mfr_back.sv
src/mode_s_frame_reencoder.sv
tb/tb_top.sv
